// ----- rtl/pst_pkg.sv -----
// Shared types, character codes and helper functions for the tokenizer.
package pst_pkg;

  localparam int unsigned MAX_OUT = 3;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_EXCL   = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Up to three output bytes caused by one input byte.
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
  } pkt_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_mark(input logic [7:0] b);
    return (b == CH_DOT) || (b == CH_APOS) || (b == CH_QUOTE) ||
           (b == CH_COMMA) || (b == CH_QUEST) || (b == CH_EXCL);
  endfunction

endpackage

// ----- rtl/punctuation_spacing_tokenizer.sv -----
// Top level of the punctuation spacing tokenizer: front end, packet queue and serialiser.
//
//  channel  | direction | handshake       | fields
//  ---------+-----------+-----------------+------------------------------
//  input    | in        | push / full     | text_byte_i, end_of_text_i
//  result   | out       | empty / pop     | out_byte_o, last_of_run_o
//
// Each input byte is classified combinationally and yields zero to three result bytes.
// The serialiser gives out one result byte per cycle while pop is held, so the sustained
// rate is one input byte per cycle while each byte yields at most one result; a byte
// with more results holds the serialiser longer and the four-entry queue absorbs this.
// An accepted request's packet is registered in the queue, then its first result byte in the output register.
// Reset clears the word state and empties the queue and the output register; no clearing pass.
module punctuation_spacing_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import pst_pkg::*;

  logic q_wr, q_rd, q_full, q_valid;
  pkt_t wr_pkt, rd_pkt;

  assign full = q_full;

  pst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .q_wr_o        (q_wr),
    .q_pkt_o       (wr_pkt)
  );

  pst_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_pkt_i (wr_pkt),
    .rd_i     (q_rd),
    .rd_pkt_o (rd_pkt),
    .full_o   (q_full),
    .valid_o  (q_valid)
  );

  pst_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pkt_i       (rd_pkt),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/pst_front.sv -----
// Front end: classifies each input byte, keeps word state and builds output packets.
module pst_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_text_i,
  input  logic          q_full_i,
  output logic          q_wr_o,
  output pst_pkg::pkt_t q_pkt_o
);
  import pst_pkg::*;

  logic       dp_q, dp_d;
  logic       wn_q, wn_d;
  logic       id_q, id_d;
  logic       accept;
  logic       ws;
  logic [6:0]      sv;
  logic [6:0][7:0] sb;
  logic [2:0]      n;
  pkt_t            pkt;

  assign accept = push_i && !q_full_i;
  assign ws     = is_ws(text_byte_i);

  // Candidate writes in model order; the first three valid ones are kept.
  always_comb begin
    sv   = '0;
    sb   = '0;
    dp_d = dp_q;
    wn_d = wn_q;
    id_d = id_q;
    if (dp_q) begin
      dp_d = 1'b0;
      if (ws) begin
        sv[0] = wn_d && !id_d;
        sb[0] = CH_SPACE;
        sv[1] = 1'b1;
        sb[1] = CH_DOT;
        sv[2] = 1'b1;
        sb[2] = CH_SPACE;
        wn_d  = 1'b0;
      end else begin
        sv[1] = 1'b1;
        sb[1] = CH_DOT;
        wn_d  = 1'b1;
        id_d  = 1'b1;
      end
    end
    if (ws) begin
      sv[3] = wn_d;
      sb[3] = CH_SPACE;
      wn_d  = 1'b0;
      id_d  = 1'b0;
    end else if ((text_byte_i == CH_DOT) && !end_of_text_i) begin
      dp_d = 1'b1;
    end else if (is_mark(text_byte_i)) begin
      sv[3] = wn_d && !id_d;
      sb[3] = CH_SPACE;
      sv[4] = 1'b1;
      sb[4] = text_byte_i;
      sv[5] = 1'b1;
      sb[5] = CH_SPACE;
      wn_d  = 1'b0;
    end else begin
      sv[4] = 1'b1;
      sb[4] = text_byte_i;
      wn_d  = 1'b1;
    end
    if (end_of_text_i) begin
      sv[6] = wn_d;
      sb[6] = CH_SPACE;
      wn_d  = 1'b0;
      id_d  = 1'b0;
      dp_d  = 1'b0;
    end
  end

  always_comb begin
    n   = '0;
    pkt = '0;
    for (int k = 0; k < 7; k++) begin
      if (sv[k] && (n < 3'(MAX_OUT))) begin
        pkt.bytes[n[1:0]] = sb[k];
        n = n + 3'd1;
      end
    end
    pkt.cnt = n[CNT_W-1:0];
  end

  assign q_wr_o  = accept && (n != '0);
  assign q_pkt_o = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q <= 1'b0;
      wn_q <= 1'b0;
      id_q <= 1'b0;
    end else if (accept) begin
      dp_q <= dp_d;
      wn_q <= wn_d;
      id_q <= id_d;
    end
  end

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable({dp_q, wn_q, id_q}))
    else $error("word state changed without an accepted request");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> !dp_q && !wn_q && !id_q)
    else $error("word state not cleared after end of text");

  a_no_empty_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o |-> (q_pkt_o.cnt != '0) && !q_full_i)
    else $error("empty packet or write into full queue");

endmodule

// ----- rtl/pst_queue.sv -----
// Short packet queue between the front end and the byte serialiser.
module pst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  pst_pkg::pkt_t wr_pkt_i,
  input  logic          rd_i,
  output pst_pkg::pkt_t rd_pkt_o,
  output logic          full_o,
  output logic          valid_o
);
  import pst_pkg::*;

  pkt_t              mem_q [Q_DEPTH];
  logic [Q_AW-1:0]   wp_q, rp_q;
  logic [Q_AW:0]     cnt_q;

  assign full_o   = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign rd_pkt_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wr_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ----- rtl/pst_back.sv -----
// Back end: serialises queued packets into single result bytes with an output register.
module pst_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pst_pkg::pkt_t q_pkt_i,
  output logic          q_rd_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o
);
  import pst_pkg::*;

  logic             ov_q;
  logic [7:0]       ob_q;
  logic             ol_q;
  logic [CNT_W-1:0] idx_q;
  logic             load;
  logic             is_last;

  assign load    = q_valid_i && (!ov_q || pop_i);
  assign is_last = (idx_q == CNT_W'(q_pkt_i.cnt - 1'b1));
  assign q_rd_o  = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= q_pkt_i.bytes[idx_q];
      ol_q <= is_last;
    end
  end

  assign empty_o       = !ov_q;
  assign out_byte_o    = ob_q;
  assign last_of_run_o = ol_q;

  a_idx_in_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> (idx_q < q_pkt_i.cnt))
    else $error("byte index beyond packet length");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid_i |-> (idx_q == '0))
    else $error("byte index not reset between packets");

  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> ov_q && ol_q)
    else $error("packet retired without a last byte in the output register");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the punctuation spacing tokenizer.
module tb_top;
  import pst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned CALM_ITEMS = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } token_t;

  // Holds the predicted word state and the result bytes still owed by the block.
  class token_scoreboard;
    token_t     tokens_due[$];
    logic [7:0] step_bytes[$];
    bit         dot_held;
    bit         word_open;
    bit         abbrev;
    int         errors;

    function bit is_blank(logic [7:0] b);
      case (b)
        CH_SPACE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_punct(logic [7:0] b);
      case (b)
        CH_DOT, CH_APOS, CH_QUOTE, CH_COMMA, CH_QUEST, CH_EXCL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void emit(logic [7:0] c);
      if (step_bytes.size() < MAX_OUT) step_bytes = {step_bytes, c};
    endfunction

    // A mark is spaced off the word only when the word has content and no inner dot.
    function void split_off(logic [7:0] c);
      if (word_open && !abbrev) emit(CH_SPACE);
      emit(c);
      emit(CH_SPACE);
      word_open = 1'b0;
    endfunction

    function void end_word();
      if (word_open) emit(CH_SPACE);
      word_open = 1'b0;
      abbrev = 1'b0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function void tokenize_byte(logic [7:0] b, logic eot);
      bit     blank;
      token_t t;
      blank = is_blank(b);
      step_bytes.delete();
      if (dot_held) begin
        dot_held = 1'b0;
        if (blank) begin
          split_off(CH_DOT);
        end else begin
          emit(CH_DOT);
          word_open = 1'b1;
          abbrev = 1'b1;
        end
      end
      if (blank) begin
        end_word();
      end else if (b == CH_DOT && !eot) begin
        dot_held = 1'b1;
      end else if (is_punct(b)) begin
        split_off(b);
      end else begin
        emit(b);
        word_open = 1'b1;
      end
      if (eot) begin
        end_word();
        dot_held = 1'b0;
      end
      foreach (step_bytes[k]) begin
        t.ch = step_bytes[k];
        t.fin = (k == step_bytes.size() - 1);
        tokens_due = {tokens_due, t};
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("tb_top: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic fin);
      token_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected result byte %h last %b", b, fin));
        return;
      end
      want = tokens_due.pop_front();
      if (b !== want.ch) report($sformatf("out_byte %h, wanted %h", b, want.ch));
      if (fin !== want.fin) report($sformatf("last_of_run %b, wanted %b", fin, want.fin));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_byte_i = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  token_scoreboard sb = new();
  bit              idle_on = 1'b1;
  int unsigned     cycles = 0;
  logic [7:0]      marks [6] = '{CH_DOT, CH_APOS, CH_QUOTE, CH_COMMA, CH_QUEST, CH_EXCL};

  punctuation_spacing_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Requests are noted before results are checked, so a same-edge pair stays in order.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.tokenize_byte(text_byte_i, end_of_text_i);
    if (rst_ni && pop && !empty) sb.check_result(out_byte_o, last_of_run_o);
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send(input logic [7:0] b, input logic eot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    text_byte_i <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_str(input string s, input logic eot);
    for (int k = 0; k < s.len(); k++) send(s[k], eot && (k == s.len() - 1));
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() > 0);
  endtask

  initial begin
    int         sel;
    logic [7:0] b;
    logic       eot;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of the byte range and the edges of the whitespace band.
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h08, 1'b0);
    send(8'h0E, 1'b0);
    send(CH_SPACE, 1'b0);
    // An abbreviation keeps its inner dots; the closing dot then meets a comma.
    send_str("e.g.,", 1'b0);
    send(8'h09, 1'b0);
    send_str("\"?!'", 1'b0);
    // A dot followed by whitespace was last in its word and is split off.
    send_str("x.", 1'b0);
    send(8'h0D, 1'b0);
    // A dot on the final byte is split off at once.
    send_str("a.", 1'b1);
    // Whitespace alone writes nothing.
    send(8'h0A, 1'b0);
    send(8'h0B, 1'b1);
    send_str("ok", 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 40) b = 8'($urandom_range(8'h61, 8'h7A));
      else if (sel < 55) b = CH_DOT;
      else if (sel < 67) b = marks[$urandom_range(0, 5)];
      else if (sel < 82) b = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(8'h09, 8'h0D));
      else b = 8'($urandom_range(0, 255));
      eot = ($urandom_range(0, 24) == 0);
      send(b, eot);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_queue.sv
rtl/pst_back.sv
rtl/punctuation_spacing_tokenizer.sv
verif/tb_top.sv
